[rtl/gpt_pkg.sv]
`default_nettype none
package gpt_pkg;

	localparam int COUNT_BITS_DEFAULT = 16;
	localparam int TIMEOUT_BITS = 16;
	localparam logic [TIMEOUT_BITS-1:0] BEACON_TIMEOUT_RESET = 16'd2000;

	localparam logic [1:0] POS_CLOSED = 2'd0;
	localparam logic [1:0] POS_MOVING = 2'd1;
	localparam logic [1:0] POS_OPEN   = 2'd2;
	localparam logic [1:0] POS_FAULT  = 2'd3;

	localparam logic [1:0] JOB_REPORT           = 2'd0;
	localparam logic [1:0] JOB_START            = 2'd1;
	localparam logic [1:0] JOB_STOP_START       = 2'd2;
	localparam logic [1:0] JOB_START_STOP_START = 2'd3;

	localparam logic LINE_START = 1'b0;
	localparam logic LINE_STOP  = 1'b1;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_PULSE  = 1'b1;

	typedef struct packed {
		logic [1:0] code;
		logic [1:0] position;
		logic       last_move_opening;
	} job_t;

endpackage
`default_nettype wire

[rtl/gpt_front.sv]
`default_nettype none
module gpt_front #(
	parameter int COUNT_BITS = gpt_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [gpt_pkg::TIMEOUT_BITS-1:0] cfg_wr_data,
	input  wire logic accept,
	input  wire logic action,
	input  wire logic beacon,
	input  wire logic photocell,
	input  wire logic open_limit,
	input  wire logic closed_limit,
	input  wire logic want_open,
	output logic push,
	output gpt_pkg::job_t job
);

	localparam int CMP_W = (COUNT_BITS > gpt_pkg::TIMEOUT_BITS) ? COUNT_BITS
		: gpt_pkg::TIMEOUT_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [gpt_pkg::TIMEOUT_BITS-1:0] timeout_q;
	logic moving_q, ldc_q;
	logic [1:0] gpos_q, rpos_q;
	logic [COUNT_BITS-1:0] quiet_q;

	logic moving_d, ldc_d;
	logic [1:0] gpos_d, rpos_d;
	logic [COUNT_BITS-1:0] quiet_d;
	logic need;
	logic [1:0] code_d;
	logic [1:0] end_pos;

	always_comb begin
		moving_d = moving_q;
		ldc_d    = ldc_q;
		gpos_d   = gpos_q;
		rpos_d   = rpos_q;
		quiet_d  = quiet_q;
		need     = 1'b0;
		code_d   = gpt_pkg::JOB_REPORT;
		end_pos  = want_open ? gpt_pkg::POS_OPEN : gpt_pkg::POS_CLOSED;
		if (!action) begin
			if (beacon) begin
				if (!moving_q)
					ldc_d = ~ldc_q;
				moving_d = 1'b1;
				quiet_d  = '0;
				gpos_d   = gpt_pkg::POS_MOVING;
			end else begin
				if (quiet_q != COUNT_MAX)
					quiet_d = quiet_q + 1'b1;
				if (CMP_W'(quiet_d) > CMP_W'(timeout_q)) begin
					moving_d = 1'b0;
					gpos_d   = gpt_pkg::POS_FAULT;
				end
			end
			if (photocell && moving_d) begin
				moving_d = 1'b0;
				gpos_d   = gpt_pkg::POS_FAULT;
			end
			if (open_limit) begin
				ldc_d  = 1'b0;
				gpos_d = gpt_pkg::POS_OPEN;
			end
			if (closed_limit) begin
				ldc_d  = 1'b1;
				gpos_d = gpt_pkg::POS_CLOSED;
			end
			if (rpos_q != gpos_d) begin
				rpos_d = gpos_d;
				need   = 1'b1;
			end
		end else begin
			if (moving_q) begin
				if (ldc_q == want_open) begin
					need   = 1'b1;
					code_d = gpt_pkg::JOB_STOP_START;
					ldc_d  = ~ldc_q;
				end
			end else if (gpos_q != end_pos) begin
				need   = 1'b1;
				code_d = (ldc_q == want_open) ? gpt_pkg::JOB_START
					: gpt_pkg::JOB_START_STOP_START;
			end
		end
	end

	assign push = accept && need;
	assign job.code = code_d;
	assign job.position = gpos_d;
	assign job.last_move_opening = ~ldc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= gpt_pkg::BEACON_TIMEOUT_RESET;
			moving_q  <= 1'b0;
			ldc_q     <= 1'b0;
			gpos_q    <= gpt_pkg::POS_CLOSED;
			rpos_q    <= gpt_pkg::POS_CLOSED;
			quiet_q   <= '0;
		end else begin
			if (cfg_wr_en)
				timeout_q <= cfg_wr_data;
			if (accept) begin
				moving_q <= moving_d;
				ldc_q    <= ldc_d;
				gpos_q   <= gpos_d;
				rpos_q   <= rpos_d;
				quiet_q  <= quiet_d;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/gpt_queue.sv]
`default_nettype none
module gpt_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  gpt_pkg::job_t push_job,
	output logic not_full,
	input  wire logic pop,
	output logic not_empty,
	output gpt_pkg::job_t pop_job
);

	gpt_pkg::job_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/gpt_back.sv]
`default_nettype none
module gpt_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	input  gpt_pkg::job_t job_in,
	output logic pop,
	output logic out_valid,
	input  wire logic out_ready,
	output logic kind,
	output logic [1:0] position,
	output logic last_move_opening,
	output logic pulse_line,
	output logic last
);

	logic busy_q;
	logic [1:0] step_q;
	gpt_pkg::job_t job_q;
	logic done;

	always_comb begin
		unique case (job_q.code)
			gpt_pkg::JOB_REPORT: begin
				pulse_line = gpt_pkg::LINE_START;
				last       = 1'b1;
			end
			gpt_pkg::JOB_START: begin
				pulse_line = gpt_pkg::LINE_START;
				last       = 1'b1;
			end
			gpt_pkg::JOB_STOP_START: begin
				pulse_line = (step_q == 2'd0) ? gpt_pkg::LINE_STOP : gpt_pkg::LINE_START;
				last       = (step_q == 2'd1);
			end
			default: begin
				pulse_line = (step_q == 2'd1) ? gpt_pkg::LINE_STOP : gpt_pkg::LINE_START;
				last       = (step_q == 2'd2);
			end
		endcase
	end

	assign kind = (job_q.code == gpt_pkg::JOB_REPORT) ? gpt_pkg::KIND_REPORT
		: gpt_pkg::KIND_PULSE;
	assign position = job_q.position;
	assign last_move_opening = job_q.last_move_opening;
	assign out_valid = busy_q;
	assign done = busy_q && out_ready && last;
	assign pop = job_valid && (!busy_q || done);

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			priority if (pop) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (busy_q && out_ready) begin
				step_q <= step_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/gate_position_tracker_and_commander.sv]
`default_nettype none
// Gate position tracker and commander. The front end takes one input transaction
// per clock while its two-entry job queue has room: sample ticks update the tracked
// state in that cycle, and sample ticks that report nothing leave no trace in the
// queue. The back end sends one result per cycle from the queue head while out_ready
// is high, so a position report gives one result and a command gives zero to three
// (stop/start pulses in button order), with the last flag on each input's final result.
// beacon_timeout is written through cfg_wr_en/cfg_wr_data and resets to 2000.
module gate_position_tracker_and_commander #(
	parameter int COUNT_BITS = gpt_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [gpt_pkg::TIMEOUT_BITS-1:0] cfg_wr_data,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic action,
	input  wire logic beacon,
	input  wire logic photocell,
	input  wire logic open_limit,
	input  wire logic closed_limit,
	input  wire logic want_open,
	output logic out_valid,
	input  wire logic out_ready,
	output logic kind,
	output logic [1:0] position,
	output logic last_move_opening,
	output logic pulse_line,
	output logic last
);

	logic push, pop, not_empty;
	gpt_pkg::job_t push_job, head_job;

	gpt_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.accept(in_valid && in_ready),
		.action(action), .beacon(beacon), .photocell(photocell),
		.open_limit(open_limit), .closed_limit(closed_limit), .want_open(want_open),
		.push(push), .job(push_job)
	);

	gpt_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_job(push_job), .not_full(in_ready),
		.pop(pop), .not_empty(not_empty), .pop_job(head_job)
	);

	gpt_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(not_empty), .job_in(head_job), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .position(position), .last_move_opening(last_move_opening),
		.pulse_line(pulse_line), .last(last)
	);

endmodule
`default_nettype wire
